>>> hdl/axis_box_region_store_assert.svh
// Assertion macros for the box region store.
// Used by the top level; no other dependencies.
`ifndef AXIS_BOX_REGION_STORE_ASSERT_SVH
`define AXIS_BOX_REGION_STORE_ASSERT_SVH
`define ABRS_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("assertion failed");
`define ABRS_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

>>> hdl/abrs_pkg.sv
// Package for the box region store: constants, codes and entry type.
// No dependencies.
`timescale 1ns / 1ps
package abrs_pkg;
	localparam int MaxBoxes = 32;
	localparam int CntW = $clog2(MaxBoxes + 1);
	localparam int AllocTries = 100;
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_POINT = 3'd2;
	localparam logic [2:0] FN_OVERLAP = 3'd3;
	localparam logic [2:0] FN_CONTAINS = 3'd4;
	localparam logic [2:0] FN_ALLOC = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_MATCH = 3'd1;
	localparam logic [2:0] ST_NONE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NOID = 3'd4;
	// id in the low bits, then lo xyz, hi xyz: same order as the input tdata
	typedef struct packed {
		logic signed [15:0] hi_z, hi_y, hi_x, lo_z, lo_y, lo_x;
		logic [31:0] id;
	} box_t;
endpackage

>>> hdl/abrs_cell.sv
// One table slot of the box chain: holds an entry and rotates it toward slot 0.
// Depends on abrs_pkg.
`timescale 1ns / 1ps
module abrs_cell (
	input  logic          clk,
	input  logic          load,
	input  abrs_pkg::box_t din,
	output abrs_pkg::box_t dout
);
	abrs_pkg::box_t ent_q;
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= din;
		end
	end
	assign dout = ent_q;
endmodule

>>> hdl/axis_box_region_store.sv
// Top level: box table as a rotating chain of cells and the request sequencer.
// Depends on abrs_pkg, abrs_cell and axis_box_region_store_assert.svh.
`timescale 1ns / 1ps
`include "axis_box_region_store_assert.svh"
// channel | dir | transfer carries
// s_axis  | in  | tuser func; tdata area_id, lo xyz, hi xyz, point xyz
// m_axis  | out | tdata status, result_id; tlast on the final result
// A request scans one full rotation of the chain, then FIN posts the result once the output
// register is free; codes 6 and 7 skip the scan and go straight to FIN.
// Allocation rescans once per id tried, up to 100 ids.
// Query matches are held one behind so tlast marks the final one; the chain stops only
// when a new match finds the output register still waiting. Input is taken only when idle.
// Reset clears the count, the id counter and the handshake state; entries are not cleared.
module axis_box_region_store (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// area_id[31:0], then lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, pt_x, pt_y, pt_z (16b each)
	input  logic [175:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser, // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata, // status[2:0], result_id[34:3], zero fill
	output logic         m_axis_tlast
);
	localparam int N = abrs_pkg::MaxBoxes;
	localparam int CW = abrs_pkg::CntW;
	localparam int TW = $clog2(abrs_pkg::AllocTries + 1);

	typedef enum logic [2:0] {IDLE = 3'b001, SCAN = 3'b010, FIN = 3'b100} st_t;
	st_t st_q;

	abrs_pkg::box_t cell_out [N];
	abrs_pkg::box_t cell_in [N];
	logic rot;
	logic wr_tail;
	abrs_pkg::box_t wr_box;

	logic [2:0] func_q;
	abrs_pkg::box_t req_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic found_q, any_q;
	logic [31:0] pid_q;
	logic [31:0] idc_q;
	logic [TW-1:0] tries_q;

	logic ov_q;
	logic [2:0] ost_q;
	logic [31:0] oid_q;
	logic olast_q;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			abrs_cell u_cell (.clk(clk), .load(rot), .din(cell_in[g]), .dout(cell_out[g]));
			if (g == N - 1) begin : g_tail
				assign cell_in[g] = wr_tail ? wr_box : cell_out[0];
			end else begin : g_mid
				assign cell_in[g] = cell_out[g + 1];
			end
		end
	endgenerate

	abrs_pkg::box_t h;
	assign h = cell_out[0];
	logic valid_h, hit, id_eq;
	assign valid_h = pos_q < cnt_q;
	// allocation looks for the candidate id, the other requests for area_id
	assign id_eq = valid_h
		&& (h.id == ((func_q == abrs_pkg::FN_ALLOC) ? idc_q : req_q.id));
	always_comb begin
		case (func_q)
			abrs_pkg::FN_POINT: hit = h.lo_x <= px_q && px_q <= h.hi_x && h.lo_y <= py_q
				&& py_q <= h.hi_y && h.lo_z <= pz_q && pz_q <= h.hi_z;
			abrs_pkg::FN_OVERLAP: hit = !(req_q.lo_x > h.hi_x || req_q.hi_x < h.lo_x)
				&& !(req_q.lo_y > h.hi_y || req_q.hi_y < h.lo_y)
				&& !(req_q.lo_z > h.hi_z || req_q.hi_z < h.lo_z);
			abrs_pkg::FN_CONTAINS: hit = req_q.lo_x <= h.lo_x && h.hi_x <= req_q.hi_x
				&& req_q.lo_y <= h.lo_y && h.hi_y <= req_q.hi_y
				&& req_q.lo_z <= h.lo_z && h.hi_z <= req_q.hi_z;
			default: hit = 1'b0;
		endcase
	end

	// one full rotation ends when the head position reaches N-1
	logic lap_end;
	assign lap_end = pos_q == CW'(N - 1);
	logic stall;
	assign stall = ov_q && !m_axis_tready;
	logic qmatch;
	assign qmatch = (func_q inside {abrs_pkg::FN_POINT, abrs_pkg::FN_OVERLAP,
		abrs_pkg::FN_CONTAINS}) && valid_h && hit;
	// insert replaces the head in place as it rotates past
	logic repl;
	assign repl = func_q == abrs_pkg::FN_INSERT && id_eq;
	// a new id lands in the first unused slot; every valid entry has been seen by then
	logic append;
	assign append = func_q == abrs_pkg::FN_INSERT && !found_q && req_q.id != 32'd0
		&& pos_q == cnt_q;
	// remove drops the matched head: rotate it out by not feeding it back at the tail
	always_comb begin
		rot = 1'b0;
		wr_tail = 1'b0;
		wr_box = req_q;
		if (st_q == SCAN && !(qmatch && any_q && stall)) begin
			rot = 1'b1;
			if (repl || append) begin
				wr_tail = 1'b1;
			end else if (func_q == abrs_pkg::FN_REMOVE && (found_q || id_eq) && valid_h) begin
				wr_tail = 1'b1;
				wr_box = (pos_q + CW'(1) < cnt_q) ? cell_out[1] : h;
			end
		end
	end

	assign s_axis_tready = st_q == IDLE && !stall;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'd0, oid_q, ost_q};
	assign m_axis_tlast = olast_q;

	logic [31:0] idn;
	assign idn = (idc_q + 32'd1 == 32'd0) ? 32'd1 : idc_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cnt_q <= '0;
			idc_q <= '0;
			ov_q <= 1'b0;
			pos_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			pid_q <= '0;
			tries_q <= '0;
			func_q <= '0;
			req_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			ost_q <= '0;
			oid_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						func_q <= s_axis_tuser;
						req_q <= s_axis_tdata[127:0];
						px_q <= s_axis_tdata[143:128];
						py_q <= s_axis_tdata[159:144];
						pz_q <= s_axis_tdata[175:160];
						pos_q <= '0;
						found_q <= 1'b0;
						any_q <= 1'b0;
						tries_q <= '0;
						if (s_axis_tuser == abrs_pkg::FN_ALLOC) begin
							idc_q <= idn;
						end
						st_q <= (s_axis_tuser <= abrs_pkg::FN_ALLOC) ? SCAN : FIN;
					end
				end
				SCAN: begin
					if (rot) begin
						if (id_eq) found_q <= 1'b1;
						if (qmatch) begin
							// the held match goes out; this one waits for the next or the end
							if (any_q) begin
								ov_q <= 1'b1;
								ost_q <= abrs_pkg::ST_MATCH;
								oid_q <= pid_q;
								olast_q <= 1'b0;
							end
							any_q <= 1'b1;
							pid_q <= h.id;
						end
						pos_q <= pos_q + CW'(1);
						if (lap_end) begin
							pos_q <= '0;
							if (func_q == abrs_pkg::FN_ALLOC && (found_q || id_eq)
								&& tries_q != TW'(abrs_pkg::AllocTries - 1)) begin
								found_q <= 1'b0;
								tries_q <= tries_q + 1'b1;
								idc_q <= idn;
							end else begin
								st_q <= FIN;
							end
						end
					end
				end
				default: begin
					if (!stall) begin
						ov_q <= 1'b1;
						olast_q <= 1'b1;
						oid_q <= '0;
						st_q <= IDLE;
						case (func_q)
							abrs_pkg::FN_INSERT: begin
								if (req_q.id == 32'd0) ost_q <= abrs_pkg::ST_NONE;
								else if (found_q) ost_q <= abrs_pkg::ST_DONE;
								else if (cnt_q >= CW'(N)) ost_q <= abrs_pkg::ST_FULL;
								else begin
									ost_q <= abrs_pkg::ST_DONE;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							abrs_pkg::FN_REMOVE: begin
								ost_q <= found_q ? abrs_pkg::ST_DONE : abrs_pkg::ST_NONE;
								if (found_q) cnt_q <= cnt_q - 1'b1;
							end
							abrs_pkg::FN_ALLOC: begin
								ost_q <= found_q ? abrs_pkg::ST_NOID : abrs_pkg::ST_DONE;
								oid_q <= found_q ? 32'd0 : idc_q;
							end
							abrs_pkg::FN_POINT, abrs_pkg::FN_OVERLAP, abrs_pkg::FN_CONTAINS: begin
								if (any_q) begin
									ost_q <= abrs_pkg::ST_MATCH;
									oid_q <= pid_q;
								end else begin
									ost_q <= abrs_pkg::ST_NONE;
								end
							end
							default: ost_q <= abrs_pkg::ST_NONE;
						endcase
					end
				end
			endcase
		end
	end

	`ABRS_ASSERT(a_cnt_max, cnt_q <= CW'(N))
	`ABRS_IMPLY(a_accept_scan, s_axis_tvalid && s_axis_tready, st_q != IDLE)
	`ABRS_ASSERT(a_no_accept_busy, !(st_q != IDLE && s_axis_tready))
endmodule
